// ===== sv/itr_pkg.sv =====
// itr_pkg: types, codes, microcode ROM and helper functions for the
// infix-to-RPN converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itr_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  // Input token kinds
  localparam logic [2:0] TK_NUM   = 3'd0;
  localparam logic [2:0] TK_OPEN  = 3'd1;
  localparam logic [2:0] TK_CLOSE = 3'd2;
  localparam logic [2:0] TK_FUNC  = 3'd3;
  localparam logic [2:0] TK_OPER  = 3'd4;

  // Operator codes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_POW  = 4'd5;
  localparam logic [3:0] OP_NEG  = 4'd6;
  localparam logic [3:0] OP_PLUS = 4'd7;
  localparam logic [3:0] OP_MAX  = 4'd7;
  localparam logic [3:0] FUNC_MAX = 4'd8;

  // Result kinds
  localparam logic [1:0] OUT_NUM  = 2'd0;
  localparam logic [1:0] OUT_FUNC = 2'd1;
  localparam logic [1:0] OUT_OPER = 2'd2;
  localparam logic [1:0] OUT_MARK = 2'd3;

  // Stack entry encoding: 0..7 operator, 8..16 function, 17 open bracket
  localparam int ENC_W = 5;
  localparam logic [ENC_W-1:0] ENC_FUNC = 5'd8;
  localparam logic [ENC_W-1:0] ENC_OPEN = 5'd17;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  tok_kind;
    logic [3:0]  tok_code;
    logic [63:0] num_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [3:0]  out_code;
    logic [63:0] out_value;
    logic        status;
    logic        last_of_run;
  } out_item_t;

  // Microcode
  localparam int UPC_W = 4;

  localparam logic [UPC_W-1:0] U_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] U_FIN    = 4'd1;
  localparam logic [UPC_W-1:0] U_NUM    = 4'd2;
  localparam logic [UPC_W-1:0] U_PUSH   = 4'd3;
  localparam logic [UPC_W-1:0] U_BAD    = 4'd4;
  localparam logic [UPC_W-1:0] U_CLOSE  = 4'd5;
  localparam logic [UPC_W-1:0] U_CLOOP  = 4'd6;
  localparam logic [UPC_W-1:0] U_CEMPTY = 4'd7;
  localparam logic [UPC_W-1:0] U_CDROP  = 4'd8;
  localparam logic [UPC_W-1:0] U_OLOOP  = 4'd9;
  localparam logic [UPC_W-1:0] U_OPUSH  = 4'd10;
  localparam logic [UPC_W-1:0] U_END    = 4'd11;
  localparam logic [UPC_W-1:0] U_ELOOP  = 4'd12;
  localparam logic [UPC_W-1:0] U_EMARK  = 4'd13;

  localparam logic [2:0] C_ALWAYS   = 3'd0;
  localparam logic [2:0] C_IN_VALID = 3'd1;
  localparam logic [2:0] C_TOP_OPER = 3'd2;
  localparam logic [2:0] C_EMPTY    = 3'd3;
  localparam logic [2:0] C_WINS     = 3'd4;
  localparam logic [2:0] C_BD_NZ    = 3'd5;
  localparam logic [2:0] C_FLUSH    = 3'd6;

  localparam logic [1:0] EM_NONE  = 2'd0;
  localparam logic [1:0] EM_NUM   = 2'd1;
  localparam logic [1:0] EM_ENTRY = 2'd2;
  localparam logic [1:0] EM_MARK  = 2'd3;

  localparam logic [1:0] BD_NONE = 2'd0;
  localparam logic [1:0] BD_INC  = 2'd1;
  localparam logic [1:0] BD_DEC  = 2'd2;

  localparam logic [1:0] EX_NONE = 2'd0;
  localparam logic [1:0] EX_SET  = 2'd1;
  localparam logic [1:0] EX_CLR  = 2'd2;

  typedef struct packed {
    logic [2:0]       cond;
    logic             dispatch;  // true target comes from token decode
    logic [UPC_W-1:0] target;
    logic             stay;      // false condition holds the step
    logic [1:0]       emit;
    logic             skip_open;
    logic             pop;
    logic             push;
    logic [1:0]       bd_op;
    logic [1:0]       exp_op;
    logic             set_err;
    logic             clear;
    logic             fin;
  } ucode_t;

  typedef struct packed {
    logic err_seen;
    logic top_oper;
    logic empty;
    logic wins;
    logic bd_nz;
    logic flush_ok;
    logic top_open;
    logic hold_valid;
    logic out_free;
  } flags_t;

  typedef struct packed {
    ucode_t word;
    logic   act;
    logic   idle;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    w = '0;
    w.cond = C_ALWAYS;
    w.target = U_FIN;
    unique case (addr)
      U_IDLE: begin
        w.cond = C_IN_VALID;
        w.dispatch = 1'b1;
        w.stay = 1'b1;
      end
      U_FIN: begin
        w.fin = 1'b1;
        w.target = U_IDLE;
      end
      U_NUM: begin
        w.emit = EM_NUM;
        w.exp_op = EX_CLR;
      end
      U_PUSH: begin
        w.push = 1'b1;
        w.exp_op = EX_SET;
        w.bd_op = BD_INC;
      end
      U_BAD: begin
        w.set_err = 1'b1;
      end
      U_CLOSE: begin
        w.bd_op = BD_DEC;
        w.exp_op = EX_CLR;
        w.target = U_CLOOP;
      end
      U_CLOOP: begin
        w.cond = C_TOP_OPER;
        w.emit = EM_ENTRY;
        w.pop = 1'b1;
        w.target = U_CLOOP;
      end
      U_CEMPTY: begin
        w.cond = C_EMPTY;
        w.set_err = 1'b1;
      end
      U_CDROP: begin
        w.pop = 1'b1;
        w.emit = EM_ENTRY;
        w.skip_open = 1'b1;
      end
      U_OLOOP: begin
        w.cond = C_WINS;
        w.emit = EM_ENTRY;
        w.pop = 1'b1;
        w.target = U_OLOOP;
      end
      U_OPUSH: begin
        w.push = 1'b1;
        w.exp_op = EX_SET;
      end
      U_END: begin
        w.cond = C_BD_NZ;
        w.set_err = 1'b1;
        w.target = U_ELOOP;
      end
      U_ELOOP: begin
        w.cond = C_FLUSH;
        w.emit = EM_ENTRY;
        w.pop = 1'b1;
        w.target = U_ELOOP;
      end
      U_EMARK: begin
        w.emit = EM_MARK;
        w.clear = 1'b1;
      end
      default: begin
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

  // Binding strength: 0 opener, 1 add/sub, 2 mul/div/mod, 3 pow, 4 unary
  function automatic logic [2:0] prec_of(input logic [ENC_W-1:0] enc);
    logic [2:0] p;
    if (enc >= ENC_FUNC) p = 3'd0;
    else if (enc <= 5'd1) p = 3'd1;
    else if (enc <= 5'd4) p = 3'd2;
    else if (enc == {1'b0, OP_POW}) p = 3'd3;
    else p = 3'd4;
    return p;
  endfunction

  function automatic logic stacked_wins(input logic [ENC_W-1:0] top,
                                        input logic [ENC_W-1:0] incoming);
    logic [2:0] pt;
    logic [2:0] pi;
    pt = prec_of(top);
    pi = prec_of(incoming);
    return (pt > pi) || ((pt == pi) && (pt == 3'd1 || pt == 3'd2));
  endfunction

  function automatic out_item_t entry_item(input logic [ENC_W-1:0] enc);
    out_item_t r;
    logic [ENC_W-1:0] fid;
    r = '0;
    fid = enc - ENC_FUNC;
    if (enc >= ENC_FUNC) begin
      r.out_kind = OUT_FUNC;
      r.out_code = fid[3:0];
    end else begin
      r.out_kind = OUT_OPER;
      r.out_code = enc[3:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/infix_to_rpn_converter.sv =====
// infix_to_rpn_converter: top level, a microcoded shunting-yard converter.
// Depends on itr_pkg, itr_sequencer, itr_datapath (which holds itr_ram).
//
// Usage:
//   in_valid/in_ready/in_data carry one token or end item per transfer.
//   out_valid/out_ready/out_data carry RPN results; last_of_run marks the
//   final result caused by an input, and the end marker's status flags an
//   expression error (drop that expression's results on error).
//   A short control program steps a plain datapath one control word per
//   cycle unless stalled; the operator stack is a RAM read one entry per
//   cycle. Per item: a number is emitted; an opener or function pushed;
//   an operator pops each stacked one that wins, then is pushed; a close
//   bracket pops down to its opener; barring an error, the end item pops
//   the rest; it then emits the end marker. Each pop is one step of the
//   stack walk, which sets the rate. One result is held back until the
//   next is known or the item ends, then moves to the output register; a
//   stalled receiver holds the program on that step. in_ready is high
//   only while the program waits for its next item. Reset empties the
//   stack, clears the bracket count and error flag and sets the
//   expect-operand flag; stack contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_rpn_converter #(
  parameter int STACK_DEPTH = itr_pkg::STACK_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire itr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output itr_pkg::out_item_t      out_data
);
  import itr_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  itr_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_data (in_data),
    .flags   (flags),
    .ctrl    (ctrl)
  );

  itr_datapath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .ctrl     (ctrl),
    .flags    (flags),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign in_ready = ctrl.idle;

endmodule

`default_nettype wire

// ===== sv/itr_ram.sv =====
// itr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module itr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/itr_sequencer.sv =====
// itr_sequencer: micro program counter, control ROM and token dispatch.
// Depends on itr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itr_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire itr_pkg::in_item_t in_data,
  input  wire itr_pkg::flags_t  flags,
  output itr_pkg::ctrl_t        ctrl
);
  import itr_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic [UPC_W-1:0] disp_target;
  ucode_t           word;
  logic             cond_true;
  logic             emit_want;
  logic             stall;

  assign word = ucode_rom(upc);

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_IN_VALID: cond_true = in_valid;
      C_TOP_OPER: cond_true = flags.top_oper;
      C_EMPTY:    cond_true = flags.empty;
      C_WINS:     cond_true = flags.wins;
      C_BD_NZ:    cond_true = flags.bd_nz;
      C_FLUSH:    cond_true = flags.flush_ok;
      default:    cond_true = 1'b0;
    endcase
  end

  // Hold the step while a result must move out and the output is full
  assign emit_want = (word.emit != EM_NONE) && !(word.skip_open && flags.top_open);
  assign stall = cond_true && flags.hold_valid && !flags.out_free &&
                 (word.fin || emit_want);

  always_comb begin
    if (in_data.req_type) begin
      disp_target = U_END;
    end else if (flags.err_seen) begin
      disp_target = U_FIN;
    end else begin
      case (in_data.tok_kind)
        TK_NUM:   disp_target = U_NUM;
        TK_OPEN:  disp_target = U_PUSH;
        TK_FUNC:  disp_target = (in_data.tok_code <= FUNC_MAX) ? U_PUSH : U_BAD;
        TK_CLOSE: disp_target = U_CLOSE;
        TK_OPER:  disp_target = (in_data.tok_code <= OP_MAX) ? U_OLOOP : U_BAD;
        default:  disp_target = U_BAD;
      endcase
    end
  end

  always_comb begin
    if (stall) begin
      upc_next = upc;
    end else if (cond_true) begin
      upc_next = word.dispatch ? disp_target : word.target;
    end else if (word.stay) begin
      upc_next = upc;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign ctrl.word = word;
  assign ctrl.act  = cond_true && !stall;
  assign ctrl.idle = (upc == U_IDLE);

  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    (upc == U_IDLE) |-> !stall)
    else $error("sequencer stalled while idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> (upc == $past(upc)))
    else $error("step advanced during a stall");

  a_fin_returns: assert property (@(posedge clk) disable iff (rst)
    (upc == U_FIN && !stall) |=> (upc == U_IDLE))
    else $error("finish step did not return to idle");

endmodule

`default_nettype wire

// ===== sv/itr_datapath.sv =====
// itr_datapath: operator stack, expression state, result hold stage and
// output register, driven by the sequencer's control word.
// Depends on itr_pkg and itr_ram.
`timescale 1ns / 1ps
`default_nettype none

module itr_datapath #(
  parameter int STACK_DEPTH = itr_pkg::STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire itr_pkg::in_item_t in_data,
  input  wire itr_pkg::ctrl_t    ctrl,
  output itr_pkg::flags_t        flags,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output itr_pkg::out_item_t     out_data
);
  import itr_pkg::*;

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int BDW = $clog2(STACK_DEPTH + 2);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  logic [SPW-1:0]   sp;
  logic [SPW-1:0]   sp_next;
  logic [SPW-1:0]   rd_ptr;
  logic [BDW-1:0]   bd;
  logic [BDW-1:0]   bd_next;
  logic             expect_opnd;
  logic             expect_opnd_next;
  logic             err;
  logic             err_next;
  logic             we;
  logic [ENC_W-1:0] top;
  logic [ENC_W-1:0] enc;
  logic [ENC_W-1:0] enc_in;
  logic [63:0]      value;
  logic             accept;
  logic             emit_now;
  out_item_t        res;
  out_item_t        hold;
  out_item_t        out_next;
  logic             hold_valid;
  logic             out_free;

  assign accept   = in_valid && ctrl.idle;
  assign out_free = !out_valid || out_ready;

  // Stack entry for the incoming token; unary conversion applies here
  always_comb begin
    case (in_data.tok_kind)
      TK_OPEN: enc_in = ENC_OPEN;
      TK_FUNC: enc_in = ENC_FUNC + {1'b0, in_data.tok_code};
      default: begin
        if (expect_opnd && in_data.tok_code == OP_SUB) enc_in = {1'b0, OP_NEG};
        else if (expect_opnd && in_data.tok_code == OP_ADD) enc_in = {1'b0, OP_PLUS};
        else enc_in = {1'b0, in_data.tok_code};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      enc   <= enc_in;
      value <= in_data.num_value;
    end
  end

  always_comb begin
    sp_next = sp;
    bd_next = bd;
    expect_opnd_next = expect_opnd;
    err_next = err;
    we = 1'b0;
    if (ctrl.act) begin
      if (ctrl.word.pop) sp_next = sp - 1'b1;
      if (ctrl.word.push) begin
        if (sp == SP_FULL) begin
          err_next = 1'b1;
        end else begin
          we = 1'b1;
          sp_next = sp + 1'b1;
        end
      end
      if (ctrl.word.set_err) err_next = 1'b1;
      case (ctrl.word.bd_op)
        BD_INC:  bd_next = bd + 1'b1;
        BD_DEC:  if (bd != '0) bd_next = bd - 1'b1;
        default: bd_next = bd;
      endcase
      case (ctrl.word.exp_op)
        EX_SET:  expect_opnd_next = 1'b1;
        EX_CLR:  expect_opnd_next = 1'b0;
        default: expect_opnd_next = expect_opnd;
      endcase
      if (ctrl.word.clear) begin
        sp_next = '0;
        bd_next = '0;
        expect_opnd_next = 1'b1;
        err_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      bd <= '0;
      expect_opnd <= 1'b1;
      err <= 1'b0;
    end else begin
      sp <= sp_next;
      bd <= bd_next;
      expect_opnd <= expect_opnd_next;
      err <= err_next;
    end
  end

  // Read ahead at the top of the next stack, so the data is ready next step
  assign rd_ptr = sp_next - 1'b1;

  itr_ram #(
    .WIDTH(ENC_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(sp[AW-1:0]),
    .wdata(enc),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(top)
  );

  assign emit_now = ctrl.act && (ctrl.word.emit != EM_NONE) &&
                    !(ctrl.word.skip_open && top == ENC_OPEN);

  always_comb begin
    res = '0;
    case (ctrl.word.emit)
      EM_NUM: begin
        res.out_kind = OUT_NUM;
        res.out_value = value;
      end
      EM_ENTRY: res = entry_item(top);
      EM_MARK: begin
        res.out_kind = OUT_MARK;
        res.status = err;
      end
      default: res = '0;
    endcase
  end

  // One result waits in hold until the next one or a finish step tells whether it was last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_now) begin
        hold_valid <= 1'b1;
      end else if (ctrl.act && ctrl.word.fin) begin
        hold_valid <= 1'b0;
      end
      if (hold_valid && (emit_now || (ctrl.act && ctrl.word.fin))) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    out_next = hold;
    out_next.last_of_run = !emit_now;
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      hold <= res;
    end
    if (hold_valid && (emit_now || (ctrl.act && ctrl.word.fin))) begin
      out_data <= out_next;
    end
  end

  assign flags.err_seen   = err;
  assign flags.top_oper   = (sp != '0) && (top < ENC_FUNC);
  assign flags.empty      = (sp == '0);
  assign flags.wins       = (sp != '0) && stacked_wins(top, enc);
  assign flags.bd_nz      = (bd != '0);
  assign flags.flush_ok   = !err && (sp != '0);
  assign flags.top_open   = (top == ENC_OPEN);
  assign flags.hold_valid = hold_valid;
  assign flags.out_free   = out_free;

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_FULL)
    else $error("stack pointer beyond depth");

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.idle |-> !hold_valid)
    else $error("result left in hold at idle");

  a_mark_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.out_kind == OUT_MARK) |-> out_data.last_of_run)
    else $error("end marker not flagged last");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (we && !ctrl.word.clear) |=> (sp == $past(sp) + 1'b1))
    else $error("push did not advance stack pointer");

endmodule

`default_nettype wire

// ===== test/infix_to_rpn_converter_tb.sv =====
// infix_to_rpn_converter_tb: self-checking bench for the shunting-yard converter.
// A scoreboard class predicts the RPN stream per token; a task drives the input
// channel, an initial block out_ready. Depends on itr_pkg and infix_to_rpn_converter.
`timescale 1ns / 1ps

module infix_to_rpn_converter_tb;
  import itr_pkg::*;

  localparam logic [3:0] OPC_MUL = 4'd2;
  localparam logic [3:0] OPC_DIV = 4'd3;
  localparam logic [3:0] OPC_MOD = 4'd4;
  localparam logic [3:0] CODE_TOP = 4'd15;
  localparam logic [2:0] TK_BAD_LO = 3'd5;
  localparam logic [2:0] TK_BAD_HI = 3'd7;
  localparam logic REQ_TOKEN = 1'b0;
  localparam logic REQ_END = 1'b1;
  localparam int USEFUL_TARGET = 200;
  localparam int LONG_HOLD_AT = 70;
  localparam int LONG_HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  infix_to_rpn_converter DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  class rpn_scoreboard;
    logic [ENC_W-1:0] held_ops[$];
    int unsigned open_count;
    bit want_operand;
    bit broken;
    out_item_t rpn_due[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      reset_expr();
    endfunction

    function void reset_expr();
      held_ops.delete();
      open_count = 0;
      want_operand = 1'b1;
      broken = 1'b0;
    endfunction

    function int pending();
      return rpn_due.size();
    endfunction

    // 0 opener, 1 add/sub, 2 mul/div/mod, 3 pow, 4 unary
    function int level_of(logic [ENC_W-1:0] enc);
      if (enc >= ENC_FUNC) return 0;
      case (enc[3:0])
        OP_ADD, OP_SUB: return 1;
        OPC_MUL, OPC_DIV, OPC_MOD: return 2;
        OP_POW: return 3;
        default: return 4;
      endcase
    endfunction

    // Pow and unary bind to the right, so equal levels only pop at 1 and 2
    function bit pops_first(logic [ENC_W-1:0] top, logic [ENC_W-1:0] incoming);
      int lt;
      int li;
      lt = level_of(top);
      li = level_of(incoming);
      return (lt > li) || (lt == li && (lt == 1 || lt == 2));
    endfunction

    function out_item_t item_of(logic [1:0] kind, logic [3:0] code, logic [63:0] value,
                                logic stat);
      out_item_t r;
      r = '0;
      r.out_kind = kind;
      r.out_code = code;
      r.out_value = value;
      r.status = stat;
      return r;
    endfunction

    function out_item_t entry_out(logic [ENC_W-1:0] enc);
      logic [ENC_W-1:0] fid;
      fid = enc - ENC_FUNC;
      if (enc >= ENC_FUNC) return item_of(OUT_FUNC, fid[3:0], '0, 1'b0);
      return item_of(OUT_OPER, enc[3:0], '0, 1'b0);
    endfunction

    // A full stack drops the push and poisons the expression
    function void push_op(logic [ENC_W-1:0] enc);
      if (held_ops.size() >= STACK_DEPTH_DEF) broken = 1'b1;
      else held_ops.push_back(enc);
    endfunction

    // Returns 0 when the token is ignored because of an earlier error
    function bit note_input(in_item_t it);
      out_item_t run[$];
      logic [3:0] code;
      logic [ENC_W-1:0] top;
      bit taken;
      taken = !(it.req_type == REQ_TOKEN && broken);
      code = it.tok_code;
      if (it.req_type == REQ_END) begin
        if (open_count != 0) broken = 1'b1;
        if (!broken)
          while (held_ops.size() > 0) run.push_back(entry_out(held_ops.pop_back()));
        run.push_back(item_of(OUT_MARK, '0, '0, broken));
        reset_expr();
      end else if (!broken) begin
        case (it.tok_kind)
          TK_NUM: begin
            run.push_back(item_of(OUT_NUM, '0, it.num_value, 1'b0));
            want_operand = 1'b0;
          end
          TK_OPEN, TK_FUNC: begin
            if (it.tok_kind == TK_FUNC && code > FUNC_MAX) begin
              broken = 1'b1;
            end else begin
              push_op(it.tok_kind == TK_OPEN ? ENC_OPEN : ENC_FUNC + {1'b0, code});
              want_operand = 1'b1;
              open_count++;
            end
          end
          TK_CLOSE: begin
            if (open_count > 0) open_count--;
            while (held_ops.size() > 0 && held_ops[$] < ENC_FUNC)
              run.push_back(entry_out(held_ops.pop_back()));
            if (held_ops.size() == 0) begin
              broken = 1'b1;
            end else begin
              top = held_ops.pop_back();
              if (top != ENC_OPEN) run.push_back(entry_out(top));
            end
            want_operand = 1'b0;
          end
          TK_OPER: begin
            if (code > OP_MAX) begin
              broken = 1'b1;
            end else begin
              if (want_operand) begin
                if (code == OP_SUB) code = OP_NEG;
                else if (code == OP_ADD) code = OP_PLUS;
              end
              while (held_ops.size() > 0 && pops_first(held_ops[$], {1'b0, code}))
                run.push_back(entry_out(held_ops.pop_back()));
              push_op({1'b0, code});
              want_operand = 1'b1;
            end
          end
          default: broken = 1'b1;
        endcase
      end
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i]) rpn_due.push_back(run[i]);
      return taken;
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: expected kind %0d code %0d value %h status %b last %b",
                 $time, what, want.out_kind, want.out_code, want.out_value, want.status,
                 want.last_of_run);
        $display("%0t %s: actual   kind %0d code %0d value %h status %b last %b",
                 $time, what, got.out_kind, got.out_code, got.out_value, got.status,
                 got.last_of_run);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (rpn_due.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = rpn_due.pop_front();
      if (got.out_kind !== want.out_kind || got.out_code !== want.out_code ||
          got.out_value !== want.out_value || got.status !== want.status ||
          got.last_of_run !== want.last_of_run)
        report("result mismatch", want, got);
    endfunction
  endclass

  rpn_scoreboard sb;
  in_item_t batch[$];
  int accepted_in = 0;
  int useful_sent = 0;
  int burst_left = 0;
  bit long_hold_done = 1'b0;

  always #10 clk = ~clk;

  initial begin
    #20000000;
    $display("infix_to_rpn_converter verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: segments of always-ready, coin-flip and mostly-stalled, plus one long hold
  initial begin
    int seg_len;
    int style;
    wait (!rst);
    forever begin
      seg_len = $urandom_range(1, 40);
      style = $urandom_range(0, 2);
      repeat (seg_len) begin
        @(posedge clk);
        if (!long_hold_done && accepted_in >= LONG_HOLD_AT) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
          long_hold_done = 1'b1;
        end
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Fields a token does not use still get random bits
  function automatic in_item_t token(logic [2:0] kind, logic [3:0] code);
    in_item_t t;
    t.req_type = REQ_TOKEN;
    t.tok_kind = kind;
    t.tok_code = code;
    t.num_value = rand64();
    return t;
  endfunction

  function automatic in_item_t num_tok(logic [63:0] value);
    in_item_t t;
    t = token(TK_NUM, 4'($urandom_range(0, CODE_TOP)));
    t.num_value = value;
    return t;
  endfunction

  function automatic in_item_t end_tok();
    in_item_t t;
    t = token(3'($urandom_range(0, 7)), 4'($urandom_range(0, CODE_TOP)));
    t.req_type = REQ_END;
    return t;
  endfunction

  function automatic in_item_t any_code(logic [2:0] kind);
    return token(kind, 4'($urandom_range(0, CODE_TOP)));
  endfunction

  function automatic in_item_t bad_tok();
    case ($urandom_range(0, 2))
      0: return any_code(3'($urandom_range(TK_BAD_LO, TK_BAD_HI)));
      1: return token(TK_FUNC, 4'($urandom_range(FUNC_MAX + 1, CODE_TOP)));
      default: return token(TK_OPER, 4'($urandom_range(OP_MAX + 1, CODE_TOP)));
    endcase
  endfunction

  // Well-formed expression with random content, sometimes broken afterwards
  function automatic void add_expr(int max_nest, int max_len);
    int nest;
    int len;
    int pick;
    int first;
    bit operand_due;
    bit done;
    nest = 0;
    len = 0;
    operand_due = 1'b1;
    done = 1'b0;
    first = batch.size();
    while (!done) begin
      len++;
      pick = $urandom_range(0, 9);
      if (operand_due) begin
        if (len >= max_len || pick < 5) begin
          batch.push_back(num_tok(rand64()));
          operand_due = 1'b0;
        end else if (pick < 8 && nest < max_nest) begin
          if (pick == 7) batch.push_back(token(TK_FUNC, 4'($urandom_range(0, FUNC_MAX))));
          else batch.push_back(any_code(TK_OPEN));
          nest++;
        end else begin
          batch.push_back(token(TK_OPER, pick[0] ? OP_SUB : OP_ADD));
        end
      end else if (nest > 0 && (pick < 3 || len >= max_len)) begin
        batch.push_back(any_code(TK_CLOSE));
        nest--;
      end else if (nest == 0 && (pick < 2 || len >= max_len)) begin
        done = 1'b1;
      end else begin
        batch.push_back(token(TK_OPER, 4'($urandom_range(OP_ADD, OP_POW))));
        operand_due = 1'b1;
      end
    end
    case ($urandom_range(0, 9))
      0: batch.insert($urandom_range(first, batch.size()), bad_tok());
      1: batch.insert($urandom_range(first, batch.size()), any_code(TK_CLOSE));
      2: if (batch.size() > first) batch.delete($urandom_range(first, batch.size() - 1));
      default: ;
    endcase
    batch.push_back(end_tok());
  endfunction

  // Long unary chain or deep nesting; past the stack depth it overflows
  function automatic void add_deep(int count, bit unary);
    repeat (count) begin
      if (unary) batch.push_back(token(TK_OPER, $urandom_range(0, 1) ? OP_SUB : OP_ADD));
      else if ($urandom_range(0, 1)) batch.push_back(any_code(TK_OPEN));
      else batch.push_back(token(TK_FUNC, 4'($urandom_range(0, FUNC_MAX))));
    end
    batch.push_back(num_tok(rand64()));
    if (!unary) repeat (count) batch.push_back(any_code(TK_CLOSE));
    batch.push_back(end_tok());
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 8))
      batch.push_back(any_code(3'($urandom_range(0, 7))));
    batch.push_back(end_tok());
  endfunction

  task automatic offer(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_input(it)) useful_sent++;
    accepted_in++;
  endtask

  task automatic send_batch();
    foreach (batch[i]) offer(batch[i]);
    batch.delete();
  endtask

  // Hold the input until every predicted result has been seen
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int expr_idx;
    int pick;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty expression
    batch.push_back(end_tok());
    // unary minus ahead of a right-associative power chain
    batch.push_back(token(TK_OPER, OP_SUB));
    batch.push_back(num_tok('0));
    batch.push_back(token(TK_OPER, OP_POW));
    batch.push_back(num_tok('1));
    batch.push_back(token(TK_OPER, OP_POW));
    batch.push_back(num_tok(rand64()));
    batch.push_back(end_tok());
    // highest function id around mixed precedence, then a binary minus
    batch.push_back(token(TK_FUNC, FUNC_MAX));
    batch.push_back(num_tok(rand64()));
    batch.push_back(token(TK_OPER, OP_ADD));
    batch.push_back(num_tok(rand64()));
    batch.push_back(token(TK_OPER, OPC_MUL));
    batch.push_back(num_tok(rand64()));
    batch.push_back(token(TK_OPER, OPC_MOD));
    batch.push_back(num_tok(rand64()));
    batch.push_back(token(TK_OPER, OPC_DIV));
    batch.push_back(num_tok(rand64()));
    batch.push_back(any_code(TK_CLOSE));
    batch.push_back(token(TK_OPER, OP_SUB));
    batch.push_back(num_tok(rand64()));
    batch.push_back(end_tok());
    // unmatched close, then an unclosed bracket
    batch.push_back(any_code(TK_CLOSE));
    batch.push_back(end_tok());
    batch.push_back(any_code(TK_OPEN));
    batch.push_back(num_tok(rand64()));
    batch.push_back(end_tok());
    send_batch();
    settle();

    useful_sent = 0;
    expr_idx = 0;
    while (useful_sent < USEFUL_TARGET) begin
      pick = $urandom_range(0, 14);
      if (expr_idx == 0) add_deep(STACK_DEPTH_DEF, 1'b1);
      else if (expr_idx == 1) add_deep(STACK_DEPTH_DEF + 1, 1'b0);
      else if (pick == 0) add_deep($urandom_range(STACK_DEPTH_DEF - 4, STACK_DEPTH_DEF + 2),
                                   1'($urandom_range(0, 1)));
      else if (pick < 3) add_noise();
      else add_expr($urandom_range(1, 6), $urandom_range(3, 20));
      send_batch();
      if (expr_idx == 4) settle();
      expr_idx++;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("infix_to_rpn_converter verification clean");
    else
      $display("infix_to_rpn_converter verification failed");
    $finish;
  end

endmodule
